FILE: hdl/hrl_pkg.sv
// Shared types, constants and helpers for the hex record loader.
`default_nettype none

package hrl_pkg;

  localparam logic [7:0]  CH_NEWLINE      = 8'h0A;
  localparam logic [7:0]  REC_DATA        = 8'h00;
  localparam logic [7:0]  REC_EOF         = 8'h01;
  localparam logic [9:0]  POS_MAX         = 10'd1023;
  localparam logic [9:0]  POS_DATA        = 10'd9;
  localparam logic [15:0] WINDOW_BASE_RST = 16'd16384;
  localparam logic [16:0] WINDOW_SIZE     = 17'd32768;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        in_window;
  } res_t;

  // Uppercase hex digit value; anything else decodes as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hrl_ch_if.sv
// Character channel: valid/ready handshake carrying one text character.
`default_nettype none

interface hrl_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

FILE: hdl/hrl_res_if.sv
// Result channel: valid/ready handshake carrying one loader result.
`default_nettype none

interface hrl_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic        in_window;

  modport source (output valid, output kind, output address, output data,
                  output in_window, input ready);
  modport sink   (input valid, input kind, input address, input data,
                  input in_window, output ready);
endinterface

`default_nettype wire

FILE: hdl/hrl_parse.sv
// Record parser: line position, header fields and per-character result decode.
`default_nettype none

module hrl_parse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   ch,
  input  wire logic [15:0]  window_base,
  output hrl_pkg::res_t     res,
  output logic              finished
);
  import hrl_pkg::*;

  logic [9:0]  pos_r,  pos_nxt;
  logic [7:0]  len_r,  len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [3:0]  hi_r,   hi_nxt;
  logic        fin_r,  fin_nxt;

  logic [3:0]  d;
  logic [9:0]  off;
  logic [8:0]  idx;
  logic [15:0] wr_addr;
  logic [16:0] win_top;

  assign d        = hex_digit(ch);
  assign off      = pos_r - POS_DATA;
  assign idx      = off[9:1];
  assign wr_addr  = addr_r + {7'd0, idx};
  assign win_top  = {1'b0, window_base} + WINDOW_SIZE;
  assign finished = fin_r;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    addr_nxt = addr_r;
    type_nxt = type_r;
    hi_nxt   = hi_r;
    fin_nxt  = fin_r;
    res      = '0;
    if (step && !fin_r) begin
      if (ch == CH_NEWLINE) begin
        pos_nxt  = '0;
        len_nxt  = '0;
        addr_nxt = '0;
        type_nxt = '0;
        hi_nxt   = '0;
      end else begin
        priority if (pos_r == 10'd1 || pos_r == 10'd7) begin
          hi_nxt = d;
        end else if (pos_r == 10'd2) begin
          len_nxt = {hi_r, d};
        end else if (pos_r >= 10'd3 && pos_r <= 10'd6) begin
          addr_nxt = {addr_r[11:0], d};
        end else if (pos_r == 10'd8) begin
          type_nxt = {hi_r, d};
          if ({hi_r, d} == REC_EOF) begin
            fin_nxt   = 1'b1;
            res.valid = 1'b1;
            res.kind  = KIND_EOF;
          end
        end else if (pos_r >= POS_DATA) begin
          if (!off[0]) begin
            hi_nxt = d;
          end else if (type_r == REC_DATA && idx < {1'b0, len_r}) begin
            // second digit of a byte inside the declared length: emit the write
            res.valid     = 1'b1;
            res.kind      = KIND_WRITE;
            res.address   = wr_addr;
            res.data      = {hi_r, d};
            res.in_window = (wr_addr >= window_base) &&
                            ({1'b0, wr_addr} < win_top);
          end
        end else begin
          // start-code position: skip
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      addr_r <= '0;
      type_r <= '0;
      hi_r   <= '0;
      fin_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      addr_r <= addr_nxt;
      type_r <= type_nxt;
      hi_r   <= hi_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hrl_out_reg.sv
// Result register driving the output channel.
`default_nettype none

module hrl_out_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hrl_pkg::res_t res,
  output logic            can_load,
  hrl_res_if.source       out_res
);
  import hrl_pkg::*;

  logic        valid_r, valid_nxt;
  logic        kind_r;
  logic [15:0] address_r;
  logic [7:0]  data_r;
  logic        in_window_r;
  logic        load;

  assign can_load = !valid_r || out_res.ready;
  assign load     = can_load && res.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r      <= res.kind;
      address_r   <= res.address;
      data_r      <= res.data;
      in_window_r <= res.in_window;
    end
  end

  assign out_res.valid     = valid_r;
  assign out_res.kind      = kind_r;
  assign out_res.address   = address_r;
  assign out_res.data      = data_r;
  assign out_res.in_window = in_window_r;

endmodule

`default_nettype wire

FILE: hdl/hex_record_loader_top.sv
// Top level of the hex record loader: input register, parser and result register.
`default_nettype none

// Streams hex-record text one character per transaction and emits one memory
// write per data byte of a type 0 record, or one end result for a type 1 record,
// after which all input is swallowed without result. A character is held in the
// input register and decoded into the result register once that register can
// load, so a result is offered after its character has passed through both
// registers. One character is accepted every cycle while the result side
// keeps up; in_ch.ready follows out_res.ready combinationally through the result
// register. Write window_base over cfg_we/cfg_wdata only while the block is idle.

module hex_record_loader_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hrl_ch_if.sink           in_ch,
  hrl_res_if.source        out_res,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import hrl_pkg::*;

  logic        s0_valid_r, s0_valid_nxt;
  logic [7:0]  s0_ch_r;
  logic [15:0] window_base_r;
  logic        can_load;
  logic        step;
  logic        finished;
  res_t        res;

  assign step        = s0_valid_r && can_load;
  assign in_ch.ready = !s0_valid_r || step;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      s0_valid_nxt = 1'b1;
    end else if (step) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      window_base_r <= WINDOW_BASE_RST;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      if (cfg_we) begin
        window_base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_ch_r <= in_ch.ch;
    end
  end

  hrl_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .ch          (s0_ch_r),
    .window_base (window_base_r),
    .res         (res),
    .finished    (finished)
  );

  hrl_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .can_load (can_load),
    .out_res  (out_res)
  );

  // once the end record is seen, no further result is produced
  a_no_res_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    finished |-> !res.valid)
    else $error("result produced after end record");

  // input stalls only when a character is held and cannot advance
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s0_valid_r && !can_load))
    else $error("input stalled without cause");

  // end result carries zero fields
  a_eof_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.kind == KIND_EOF) |->
      (out_res.address == 16'd0 && out_res.data == 8'd0 && !out_res.in_window))
    else $error("end result with non-zero fields");

  // an end result being issued sets the finished flag on the next edge
  a_eof_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_EOF) |=> finished)
    else $error("finished flag not set after end record");

endmodule

`default_nettype wire
